@@ rtl/irdpfe_pkg.sv @@
// ----------------------------------------------------------------------------
// irdpfe_pkg: shared types and constants
// Widths, register indexes and the payload helper for the IR dibit pulse
// frame encoder.
// ----------------------------------------------------------------------------
package irdpfe_pkg;

    localparam int unsigned CODE_W     = 8;
    localparam int unsigned PAYLOAD_W  = 20;
    localparam int unsigned UNIT_W     = 12;
    localparam int unsigned HEADER_W   = 15;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned SYM_W      = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    // Running frame time: header plus twelve marks and ten spaces of up to
    // five units each stays below 2^19.
    localparam int unsigned ELAPSED_W  = 19;

    localparam logic [SYM_W-1:0] SYM_HEADER  = 4'd0;
    localparam logic [SYM_W-1:0] SYM_FIRST   = 4'd1;
    localparam logic [SYM_W-1:0] SYM_TRAILER = 4'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_TIME   = 2'd0,
        CFG_HEADER_MARK = 2'd1,
        CFG_FRAME_PER   = 2'd2
    } t_cfg_idx;

    typedef logic [PAYLOAD_W-1:0] t_payload;

    typedef struct packed {
        logic     valid;
        t_payload payload;
    } t_req;

    function automatic t_payload build_payload(input logic [CODE_W-1:0] dev,
                                               input logic [CODE_W-1:0] fun);
        logic [3:0] sum;
        sum = dev[7:4] ^ dev[3:0] ^ fun[7:4] ^ fun[3:0];
        return {dev, fun, sum};
    endfunction

endpackage

@@ rtl/irdpfe_req_if.sv @@
// ----------------------------------------------------------------------------
// irdpfe_req_if: frame request channel
// Carries the device and function bytes of one frame request.
// ----------------------------------------------------------------------------
interface irdpfe_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_code;
    logic [7:0] function_code;

    modport source (output valid, output device_code, output function_code, input ready);
    modport sink   (input valid, input device_code, input function_code, output ready);
endinterface

@@ rtl/irdpfe_sym_if.sv @@
// ----------------------------------------------------------------------------
// irdpfe_sym_if: symbol channel
// Carries one mark/space symbol of an encoded frame.
// ----------------------------------------------------------------------------
interface irdpfe_sym_if;
    logic        valid;
    logic        ready;
    logic [15:0] mark_time;
    logic [15:0] space_time;
    logic [3:0]  symbol_number;
    logic        last_symbol;

    modport source (output valid, output mark_time, output space_time,
                    output symbol_number, output last_symbol, input ready);
    modport sink   (input valid, input mark_time, input space_time,
                    input symbol_number, input last_symbol, output ready);
endinterface

@@ rtl/irdpfe_front.sv @@
// ----------------------------------------------------------------------------
// irdpfe_front: request intake
// Accepts request words, builds the checksummed payload and holds it in a
// two-entry queue for the symbol sequencer.
// ----------------------------------------------------------------------------
module irdpfe_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    irdpfe_req_if.sink              i_req,
    input  logic                    i_pop,
    output irdpfe_pkg::t_req        o_head
);

    irdpfe_pkg::t_payload r_slot [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count;
    logic                 push;
    logic                 pop;

    assign i_req.ready = (r_count != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_count != 2'd0);

    assign o_head.valid   = (r_count != 2'd0);
    assign o_head.payload = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= irdpfe_pkg::build_payload(i_req.device_code,
                                                          i_req.function_code);
        end
    end

endmodule

@@ rtl/irdpfe_back.sv @@
// ----------------------------------------------------------------------------
// irdpfe_back: symbol sequencer
// Walks one queued payload through its twelve symbols, one per cycle while
// o_sym is not stalled, and drives the registered symbol channel.
// ----------------------------------------------------------------------------
module irdpfe_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [irdpfe_pkg::UNIT_W-1:0]         i_unit,
    input  logic [irdpfe_pkg::HEADER_W-1:0]       i_header,
    input  logic [irdpfe_pkg::PERIOD_W-1:0]       i_period,
    input  irdpfe_pkg::t_req                      i_head,
    output logic                                  o_pop,
    irdpfe_sym_if.source                          o_sym
);

    localparam int unsigned TW = irdpfe_pkg::TIME_W;
    localparam int unsigned EW = irdpfe_pkg::ELAPSED_W;
    localparam int unsigned PW = irdpfe_pkg::PAYLOAD_W;

    logic                           r_busy;
    logic [irdpfe_pkg::SYM_W-1:0]   r_sym;
    irdpfe_pkg::t_payload           r_shift;
    logic [EW-1:0]                  r_elapsed;
    logic                           r_out_valid;
    logic [TW-1:0]                  r_mark;
    logic [TW-1:0]                  r_space;
    logic [irdpfe_pkg::SYM_W-1:0]   r_num;
    logic                           r_last;

    logic [TW-1:0]  mark;
    logic [TW-1:0]  unit;
    logic [TW-1:0]  unit4;
    logic [TW-1:0]  space;
    logic [TW-1:0]  tail;
    logic [EW-1:0]  step;
    logic [1:0]     dibit;
    logic           advance;
    logic           start;

    assign mark  = {3'b000, i_unit, 1'b0};
    assign unit  = {4'b0000, i_unit};
    assign unit4 = {2'b00, i_unit, 2'b00};
    assign dibit = r_shift[PW-1 -: 2];

    always_comb begin
        case (dibit)
            2'd0:    space = mark;
            2'd1:    space = mark + unit;
            2'd2:    space = unit4;
            default: space = unit4 + unit;
        endcase
    end

    assign step = {3'b000, space} + {3'b000, mark};

    always_comb begin
        if (r_elapsed < {3'b000, i_period}) begin
            tail = i_period - r_elapsed[TW-1:0];
        end else begin
            tail = mark;
        end
    end

    assign advance = !r_out_valid || o_sym.ready;
    assign start   = advance && !r_busy && i_head.valid;
    assign o_pop   = start;

    assign o_sym.valid         = r_out_valid;
    assign o_sym.mark_time     = r_mark;
    assign o_sym.space_time    = r_space;
    assign o_sym.symbol_number = r_num;
    assign o_sym.last_symbol   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sym       <= irdpfe_pkg::SYM_HEADER;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            if (start) begin
                r_busy      <= 1'b1;
                r_sym       <= irdpfe_pkg::SYM_FIRST;
                r_out_valid <= 1'b1;
            end else if (r_busy) begin
                r_busy      <= (r_sym != irdpfe_pkg::SYM_TRAILER);
                r_sym       <= r_sym + 4'd1;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (start) begin
                r_shift   <= i_head.payload;
                // Header, its space and the trailer mark are counted up front.
                r_elapsed <= {4'b0000, i_header} + {3'b000, unit4};
                r_mark    <= {1'b0, i_header};
                r_space   <= mark;
                r_num     <= irdpfe_pkg::SYM_HEADER;
                r_last    <= 1'b0;
            end else if (r_busy) begin
                r_shift   <= {r_shift[PW-3:0], 2'b00};
                r_elapsed <= r_elapsed + step;
                r_mark    <= mark;
                r_space   <= (r_sym == irdpfe_pkg::SYM_TRAILER) ? tail : space;
                r_num     <= r_sym;
                r_last    <= (r_sym == irdpfe_pkg::SYM_TRAILER);
            end
        end
    end

endmodule

@@ rtl/ir_dibit_pulse_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// ir_dibit_pulse_frame_encoder: IR dibit pulse-distance frame encoder
// Turns a device and function byte into a twelve-symbol mark/space frame.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// i_req     in         device_code, function_code
// o_sym     out        mark_time, space_time, symbol_number, last_symbol
// i_cfg_*   in         register write: index, data
//
// Each request gives twelve symbols, one per cycle from the sequencer while o_sym
// is not stalled; a two-entry queue lets requests be taken while a frame is
// still being sent.
// Reset is synchronous, clears the queue and sequencer and restores the
// register defaults. A stall on o_sym holds the symbol register and the
// sequencer; requests are still taken until the queue is full.
module ir_dibit_pulse_frame_encoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [irdpfe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [irdpfe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    irdpfe_req_if.sink                           i_req,
    irdpfe_sym_if.source                         o_sym
);

    logic [irdpfe_pkg::UNIT_W-1:0]   r_unit;
    logic [irdpfe_pkg::HEADER_W-1:0] r_header;
    logic [irdpfe_pkg::PERIOD_W-1:0] r_period;
    irdpfe_pkg::t_req                head;
    logic                            pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit   <= 12'd290;
            r_header <= 15'd1000;
            r_period <= 16'd30000;
        end else if (i_cfg_we) begin
            unique case (irdpfe_pkg::t_cfg_idx'(i_cfg_idx))
                irdpfe_pkg::CFG_UNIT_TIME:   r_unit   <= i_cfg_data[irdpfe_pkg::UNIT_W-1:0];
                irdpfe_pkg::CFG_HEADER_MARK: r_header <= i_cfg_data[irdpfe_pkg::HEADER_W-1:0];
                irdpfe_pkg::CFG_FRAME_PER:   r_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    irdpfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_head  (head)
    );

    irdpfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_unit   (r_unit),
        .i_header (r_header),
        .i_period (r_period),
        .i_head   (head),
        .o_pop    (pop),
        .o_sym    (o_sym)
    );

endmodule

@@ rtl/irdpfe_checker.sv @@
// ----------------------------------------------------------------------------
// irdpfe_checker: port-level checks
// Watches the symbol channel of the frame encoder over time.
// ----------------------------------------------------------------------------
module irdpfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [15:0] i_mark,
    input logic [15:0] i_space,
    input logic [3:0]  i_num,
    input logic        i_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_valid)
        else $error("symbol valid straight after reset");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_num == irdpfe_pkg::SYM_TRAILER)))
        else $error("last flag does not match the trailer symbol");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("symbol dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_mark) && $stable(i_space) && $stable(i_num))
        else $error("symbol changed while stalled");

endmodule

bind ir_dibit_pulse_frame_encoder irdpfe_checker u_irdpfe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_sym.valid),
    .i_ready (o_sym.ready),
    .i_mark  (o_sym.mark_time),
    .i_space (o_sym.space_time),
    .i_num   (o_sym.symbol_number),
    .i_last  (o_sym.last_symbol)
);
